// ===== hdl/format_integer_to_ascii_defines.svh =====
// Assertion macros shared by the formatter modules.
`ifndef FORMAT_INTEGER_TO_ASCII_DEFINES_SVH
`define FORMAT_INTEGER_TO_ASCII_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define FITA_ASSERT_IMP(NAME, ANT, CONS, MSG) \
  NAME: assert property (@(posedge clk_i) disable iff (!rst_ni) (ANT) |-> (CONS)) \
    else $error(MSG);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define FITA_ASSERT_NXT(NAME, ANT, CONS, MSG) \
  NAME: assert property (@(posedge clk_i) disable iff (!rst_ni) (ANT) |=> (CONS)) \
    else $error(MSG);

`endif

// ===== hdl/fita_pkg.sv =====
// Types, character codes and helpers shared by the integer formatter.
package fita_pkg;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_MINUS   = 8'h2d;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_C = 8'h63;
  localparam logic [7:0] CH_LOWER_D = 8'h64;
  localparam logic [7:0] CH_LOWER_O = 8'h6f;
  localparam logic [7:0] CH_LOWER_P = 8'h70;
  localparam logic [7:0] CH_LOWER_U = 8'h75;
  localparam logic [7:0] CH_LOWER_X = 8'h78;

  // x / 10 == (x * RECIP10) >> RECIP_SHIFT for every 32-bit x.
  localparam logic [31:0] RECIP10     = 32'hcccc_cccd;
  localparam int unsigned RECIP_SHIFT = 35;
  localparam int unsigned PROD_W      = 64;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ECHO,
    ST_MUL,
    ST_SUB,
    ST_SHIFT,
    ST_SIGN,
    ST_PFX0,
    ST_PFXX,
    ST_EMIT
  } fita_state_e;

  typedef enum logic [1:0] {
    BASE_8,
    BASE_10,
    BASE_16
  } fita_base_e;

  typedef enum logic [2:0] {
    LD_NONE,
    LD_FMT,
    LD_ARG_BYTE,
    LD_U32,
    LD_S32,
    LD_U64
  } fita_load_e;

  typedef enum logic [2:0] {
    EM_CHAR,
    EM_MINUS,
    EM_ZERO,
    EM_X,
    EM_DIGIT
  } fita_emit_e;

  typedef struct packed {
    fita_load_e ld;
    fita_base_e base;
    logic       mul;
    logic       step;
    logic       push;
    fita_emit_e sel;
    logic       last;
  } fita_cmd_t;

  typedef struct packed {
    logic step_last;
    logic cnt_one;
    logic out_free;
  } fita_stat_t;

  function automatic logic [7:0] hex_char(input logic [3:0] digit);
    logic [7:0] ext;
    ext = {4'h0, digit};
    if (digit < 4'd10) begin
      return CH_ZERO + ext;
    end
    return (CH_LOWER_A - 8'd10) + ext;
  endfunction

endpackage

// ===== hdl/fita_in_if.sv =====
// Input channel: one format byte and its argument word per beat.
interface fita_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  fmt_byte;
  logic [63:0] arg_value;

  modport source (output valid, output fmt_byte, output arg_value, input ready);
  modport sink (input valid, input fmt_byte, input arg_value, output ready);
endinterface

// ===== hdl/fita_out_if.sv =====
// Output channel: one ASCII character per beat, with an end-of-item marker.
interface fita_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output out_byte, output last, input ready);
  modport sink (input valid, input out_byte, input last, output ready);
endinterface

// ===== hdl/fita_ctrl.sv =====
// Controller: format byte decoding and sequencing of conversion and output.
`include "format_integer_to_ascii_defines.svh"

module fita_ctrl import fita_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [7:0] in_fmt_i,
  input  logic       in_sign_i,
  output logic       in_ready_o,
  input  fita_stat_t stat_i,
  output fita_cmd_t  cmd_o
);

  fita_state_e state_q, state_d;
  logic        pend_q, pend_d;
  logic        neg_q, neg_d;
  logic        pfx_q, pfx_d;

  fita_load_e  dec_ld;
  fita_base_e  dec_base;
  fita_state_e dec_next;
  logic        dec_neg;
  logic        dec_pfx;
  fita_state_e after_digits;

  // What the byte at the input means, given the pending percent.
  always_comb begin
    dec_ld   = LD_NONE;
    dec_base = BASE_10;
    dec_next = ST_IDLE;
    dec_neg  = 1'b0;
    dec_pfx  = 1'b0;
    if (!pend_q) begin
      if (in_fmt_i != CH_PERCENT) begin
        dec_ld   = LD_FMT;
        dec_next = ST_ECHO;
      end
    end else begin
      unique case (in_fmt_i)
        CH_LOWER_D: begin
          dec_ld   = LD_S32;
          dec_next = ST_MUL;
          dec_neg  = in_sign_i;
        end
        CH_LOWER_U: begin
          dec_ld   = LD_U32;
          dec_next = ST_MUL;
        end
        CH_LOWER_O: begin
          dec_ld   = LD_U32;
          dec_base = BASE_8;
          dec_next = ST_SHIFT;
        end
        CH_LOWER_X: begin
          dec_ld   = LD_U32;
          dec_base = BASE_16;
          dec_next = ST_SHIFT;
        end
        CH_LOWER_P: begin
          dec_ld   = LD_U64;
          dec_base = BASE_16;
          dec_next = ST_SHIFT;
          dec_pfx  = 1'b1;
        end
        CH_LOWER_C: begin
          dec_ld   = LD_ARG_BYTE;
          dec_next = ST_ECHO;
        end
        CH_PERCENT: begin
          dec_ld   = LD_FMT;
          dec_next = ST_ECHO;
        end
        default: begin
          dec_next = ST_IDLE;
        end
      endcase
    end
  end

  assign after_digits = neg_q ? ST_SIGN : (pfx_q ? ST_PFX0 : ST_EMIT);

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    neg_d   = neg_q;
    pfx_d   = pfx_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          pend_d  = !pend_q && (in_fmt_i == CH_PERCENT);
          state_d = dec_next;
          neg_d   = dec_neg;
          pfx_d   = dec_pfx;
        end
      end
      ST_ECHO: begin
        if (stat_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      ST_MUL: begin
        state_d = ST_SUB;
      end
      ST_SUB: begin
        state_d = stat_i.step_last ? after_digits : ST_MUL;
      end
      ST_SHIFT: begin
        if (stat_i.step_last) begin
          state_d = after_digits;
        end
      end
      ST_SIGN: begin
        if (stat_i.out_free) begin
          state_d = ST_EMIT;
        end
      end
      ST_PFX0: begin
        if (stat_i.out_free) begin
          state_d = ST_PFXX;
        end
      end
      ST_PFXX: begin
        if (stat_i.out_free) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free && stat_i.cnt_one) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '{ld: LD_NONE, base: BASE_10, mul: 1'b0, step: 1'b0,
                   push: 1'b0, sel: EM_CHAR, last: 1'b0};
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.ld   = dec_ld;
          cmd_o.base = dec_base;
        end
      end
      ST_ECHO: begin
        cmd_o.push = stat_i.out_free;
        cmd_o.sel  = EM_CHAR;
        cmd_o.last = 1'b1;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
      end
      ST_SUB, ST_SHIFT: begin
        cmd_o.step = 1'b1;
      end
      ST_SIGN: begin
        cmd_o.push = stat_i.out_free;
        cmd_o.sel  = EM_MINUS;
      end
      ST_PFX0: begin
        cmd_o.push = stat_i.out_free;
        cmd_o.sel  = EM_ZERO;
      end
      ST_PFXX: begin
        cmd_o.push = stat_i.out_free;
        cmd_o.sel  = EM_X;
      end
      ST_EMIT: begin
        cmd_o.push = stat_i.out_free;
        cmd_o.sel  = EM_DIGIT;
        cmd_o.last = stat_i.cnt_one;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      neg_q   <= 1'b0;
      pfx_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      neg_q   <= neg_d;
      pfx_q   <= pfx_d;
    end
  end

  // A pending percent only ever waits for the next byte at the input.
  `FITA_ASSERT_IMP(a_pend_only_idle, pend_q, state_q == ST_IDLE, "percent pending outside idle")
  // The final character of an item always returns control to the input.
  `FITA_ASSERT_NXT(a_last_to_idle, cmd_o.push && cmd_o.last, state_q == ST_IDLE, "no idle after last")
  // Nothing is loaded unless an input beat is taken.
  `FITA_ASSERT_IMP(a_load_on_beat, cmd_o.ld != LD_NONE, in_valid_i && in_ready_o, "load without beat")

endmodule

// ===== hdl/fita_datapath.sv =====
// Datapath: argument register, digit extraction, digit store and output register.
`include "format_integer_to_ascii_defines.svh"

module fita_datapath import fita_pkg::*; #(
  parameter int unsigned DIGIT_DEPTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [7:0]  fmt_byte_i,
  input  logic [63:0] arg_value_i,
  input  fita_cmd_t   cmd_i,
  output fita_stat_t  stat_o,
  fita_out_if.source  chr_o
);

  localparam int unsigned CntW  = $clog2(DIGIT_DEPTH + 1);
  localparam int unsigned IdxW  = $clog2(DIGIT_DEPTH);
  localparam int unsigned QuotW = PROD_W - RECIP_SHIFT;

  logic [7:0]        char_q, char_d;
  logic [63:0]       value_q, value_d;
  fita_base_e        base_q, base_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [PROD_W-1:0] prod_q, prod_d;
  logic [3:0]        store_q [DIGIT_DEPTH];
  logic [3:0]        rd_digit_q;
  logic              out_valid_q, out_valid_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;

  logic [QuotW-1:0]  quot;
  logic [3:0]        quot_x10;
  logic [3:0]        digit_new;
  logic [63:0]       val_next;
  logic [CntW-1:0]   cnt_m1;
  logic [CntW-1:0]   rd_ptr;
  logic              out_free;
  logic              number_load;
  logic              pop;

  assign quot     = prod_q[PROD_W-1:RECIP_SHIFT];
  // Only the low four bits of quot * 10 are needed for the remainder.
  assign quot_x10 = 4'({quot[3:0], 3'b000} + {2'b00, quot[3:0], 1'b0});

  always_comb begin
    case (base_q)
      BASE_10: begin
        digit_new = value_q[3:0] - quot_x10;
        val_next  = 64'(quot);
      end
      BASE_8: begin
        digit_new = {1'b0, value_q[2:0]};
        val_next  = value_q >> 3;
      end
      default: begin
        digit_new = value_q[3:0];
        val_next  = value_q >> 4;
      end
    endcase
  end

  assign cnt_m1   = cnt_q - CntW'(1);
  assign rd_ptr   = cnt_d - CntW'(1);
  assign out_free = !out_valid_q || chr_o.ready;
  assign number_load = (cmd_i.ld == LD_U32) || (cmd_i.ld == LD_S32) || (cmd_i.ld == LD_U64);
  assign pop      = cmd_i.push && (cmd_i.sel == EM_DIGIT);

  assign stat_o.step_last = (val_next == '0) || (cnt_q == CntW'(DIGIT_DEPTH - 1));
  assign stat_o.cnt_one   = (cnt_q == CntW'(1));
  assign stat_o.out_free  = out_free;

  always_comb begin
    char_d  = char_q;
    value_d = value_q;
    case (cmd_i.ld)
      LD_FMT:      char_d  = fmt_byte_i;
      LD_ARG_BYTE: char_d  = arg_value_i[7:0];
      LD_U32:      value_d = {32'h0, arg_value_i[31:0]};
      // The unsigned negation gives the correct magnitude for the most negative value.
      LD_S32:      value_d = {32'h0, arg_value_i[31] ? (32'h0 - arg_value_i[31:0])
                                                     : arg_value_i[31:0]};
      LD_U64:      value_d = arg_value_i;
      default: begin
        if (cmd_i.step) begin
          value_d = val_next;
        end
      end
    endcase
  end

  always_comb begin
    base_d = number_load ? cmd_i.base : base_q;
    prod_d = cmd_i.mul ? (64'(value_q[31:0]) * 64'(RECIP10)) : prod_q;
    if (number_load) begin
      cnt_d = '0;
    end else if (cmd_i.step) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop) begin
      cnt_d = cnt_m1;
    end else begin
      cnt_d = cnt_q;
    end
  end

  always_comb begin
    case (cmd_i.sel)
      EM_MINUS: out_byte_d = CH_MINUS;
      EM_ZERO:  out_byte_d = CH_ZERO;
      EM_X:     out_byte_d = CH_LOWER_X;
      EM_DIGIT: out_byte_d = hex_char(rd_digit_q);
      default:  out_byte_d = char_q;
    endcase
    out_last_d = cmd_i.last;
    if (cmd_i.push) begin
      out_valid_d = 1'b1;
    end else if (chr_o.ready) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q  <= char_d;
    value_q <= value_d;
    base_q  <= base_d;
    prod_q  <= prod_d;
    if (cmd_i.push) begin
      out_byte_q <= out_byte_d;
      out_last_q <= out_last_d;
    end
  end

  // Digits are stored least significant first. The read port fetches the digit that
  // the next pop needs in advance, and a digit being written passes straight through.
  always_ff @(posedge clk_i) begin
    if (cmd_i.step) begin
      store_q[cnt_q[IdxW-1:0]] <= digit_new;
      rd_digit_q               <= digit_new;
    end else begin
      rd_digit_q <= store_q[rd_ptr[IdxW-1:0]];
    end
  end

  assign chr_o.valid    = out_valid_q;
  assign chr_o.out_byte = out_byte_q;
  assign chr_o.last     = out_last_q;

  `FITA_ASSERT_IMP(a_step_room, cmd_i.step, cnt_q < CntW'(DIGIT_DEPTH), "digit store overrun")
  `FITA_ASSERT_IMP(a_push_room, cmd_i.push, !out_valid_q || chr_o.ready, "output beat overwritten")
  `FITA_ASSERT_IMP(a_pop_filled, pop, cnt_q != '0, "digit read from an empty store")

endmodule

// ===== hdl/format_integer_to_ascii.sv =====
// Minimal printf-style integer formatter, top level.
// Input channel fmt_i: one beat per format byte, with the argument word beside it.
// Output channel chr_o: one beat per ASCII character; last marks an item's final one.
// An ordinary byte is echoed; '%' arms the next byte as a specifier (d u o x p c %).
// Input is taken only while no item is in progress, so items are handled one by one.
// Every character that the controller produces is held in the output register.
// An echo, %c or %% produces one character; a percent sign alone produces none.
// Conversions: decimal does a registered reciprocal multiply, then the remainder step,
// for each digit; octal and hex do a shift step for each digit. Then the sign or
// prefix characters and the digits are output, most significant digit first.
// Reset clears the controller and empties the output register; a pending percent is
// forgotten. When the receiver stalls, the held beat stays in the output register and
// the controller waits in its current output step; a new item may still be accepted
// while the final beat of the previous one waits.
module format_integer_to_ascii import fita_pkg::*; #(
  parameter int unsigned DIGIT_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fita_in_if.sink    fmt_i,
  fita_out_if.source chr_o
);

  fita_cmd_t  cmd;
  fita_stat_t stat;
  logic       in_ready;

  assign fmt_i.ready = in_ready;

  fita_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (fmt_i.valid),
    .in_fmt_i   (fmt_i.fmt_byte),
    .in_sign_i  (fmt_i.arg_value[31]),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  fita_datapath #(
    .DIGIT_DEPTH (DIGIT_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fmt_byte_i  (fmt_i.fmt_byte),
    .arg_value_i (fmt_i.arg_value),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .chr_o       (chr_o)
  );

endmodule
